[hw/rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, muted while reset is held
`define GNC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, muted while reset is held
`define GNC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/gnc_pkg.sv]
`timescale 1ns / 1ps

package gnc_pkg;

    localparam int MAX_COLS      = 64;
    localparam int MAX_ROWS      = 64;
    localparam int STATE_BITS    = 4;
    localparam int MAX_RADIUS    = 7;

    localparam int OP_BITS       = 3;
    localparam int COL_BITS      = 6;
    localparam int ROW_BITS      = 6;
    localparam int RAD_BITS      = 3;
    localparam int COUNT_BITS    = 8;
    localparam int DIM_BITS      = 7;
    localparam int SPAN_BITS     = 4;
    localparam int COORD_BITS    = 8;

    localparam int ADDR_BITS     = COL_BITS + ROW_BITS;
    localparam int CELLS         = MAX_COLS * MAX_ROWS;
    localparam int MAX_COUNT     = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 7;

    localparam logic [OP_BITS-1:0] OP_WRITE  = 3'd0;
    localparam logic [OP_BITS-1:0] OP_READ   = 3'd1;
    localparam logic [OP_BITS-1:0] OP_SQUARE = 3'd2;
    localparam logic [OP_BITS-1:0] OP_FOUR   = 3'd3;
    localparam logic [OP_BITS-1:0] OP_EIGHT  = 3'd4;

    localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WRAP_MODE   = 2'd2;

    typedef logic [STATE_BITS-1:0] t_cell;
    typedef logic [ADDR_BITS-1:0]  t_addr;
    typedef logic [COUNT_BITS-1:0] t_count;

    typedef struct packed {
        logic [OP_BITS-1:0]    op;
        logic [COL_BITS-1:0]   col;
        logic [ROW_BITS-1:0]   row;
        logic [STATE_BITS-1:0] cell_state;
        logic [RAD_BITS-1:0]   radius;
    } t_in_word;

    typedef struct packed {
        logic [COUNT_BITS-1:0] match_count;
        logic [STATE_BITS-1:0] cell_value;
    } t_out_word;

    // effective grid settings, already clamped
    typedef struct packed {
        logic [DIM_BITS-1:0] width;
        logic [DIM_BITS-1:0] height;
        logic                wrap;
    } t_grid_cfg;

    typedef struct packed {
        logic  clear;
        logic  sample;
        logic  centre;
        logic  skip_en;
        t_cell st;
    } t_cnt_ctrl;

    typedef enum logic [1:0] {
        RES_ZERO  = 2'd0,
        RES_READ  = 2'd1,
        RES_COUNT = 2'd2
    } t_res_kind;

    typedef struct packed {
        logic      result_ready;
        t_res_kind kind;
    } t_seq_status;

endpackage

[hw/rtl/gnc_ram.sv]
`timescale 1ns / 1ps

module gnc_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/gnc_count.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gnc_count (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gnc_pkg::t_cnt_ctrl i_ctrl,
    input  gnc_pkg::t_cell     i_rd_data,
    output gnc_pkg::t_count    o_count,
    output gnc_pkg::t_cell     o_value
);

    import gnc_pkg::*;

    logic   r_sample;
    logic   r_centre;
    logic   r_skip_en;
    logic   r_skipped;
    t_cell  r_st;
    t_count r_count;
    t_cell  r_value;

    logic   n_skipped;
    t_count n_count;
    logic   hit;
    logic   drop;

    // read data lands in the cycle after the address, so the tags are registered to match
    always_comb begin
        hit       = r_sample && (i_rd_data == r_st);
        drop      = r_sample && r_skip_en && r_centre && !r_skipped;
        n_skipped = r_skipped;
        n_count   = r_count;
        if (i_ctrl.clear) begin
            n_skipped = 1'b0;
            n_count   = '0;
        end else begin
            if (drop) begin
                // first visit of the centre is left out of the count
                n_skipped = 1'b1;
            end else if (hit && (r_count != '1)) begin
                n_count = r_count + COUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample  <= 1'b0;
            r_centre  <= 1'b0;
            r_skip_en <= 1'b0;
            r_skipped <= 1'b0;
            r_count   <= '0;
        end else begin
            r_sample  <= i_ctrl.sample;
            r_centre  <= i_ctrl.centre;
            r_skip_en <= i_ctrl.skip_en;
            r_skipped <= n_skipped;
            r_count   <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear) begin
            r_st <= i_ctrl.st;
        end
        if (r_sample) begin
            r_value <= i_rd_data;
        end
    end

    assign o_count = r_count;
    assign o_value = r_value;

    `GNC_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= COUNT_BITS'(MAX_COUNT), "count exceeds the largest window")

endmodule

[hw/rtl/gnc_seq.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gnc_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  gnc_pkg::t_in_word    i_in_word,
    input  gnc_pkg::t_grid_cfg   i_cfg,
    input  logic                 i_out_free,
    output gnc_pkg::t_seq_status o_status,
    output gnc_pkg::t_cnt_ctrl   o_cnt_ctrl,
    output logic                 o_wr_en,
    output gnc_pkg::t_addr       o_wr_addr,
    output gnc_pkg::t_cell       o_wr_data,
    output logic                 o_rd_en,
    output gnc_pkg::t_addr       o_rd_addr
);

    import gnc_pkg::*;

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_PREP  = 7'b0000100,
        ST_SCAN  = 7'b0001000,
        ST_SCAN4 = 7'b0010000,
        ST_DRAIN = 7'b0100000,
        ST_DONE  = 7'b1000000
    } t_state;

    localparam logic [1:0] STEP_LEFT  = 2'd0;
    localparam logic [1:0] STEP_RIGHT = 2'd1;
    localparam logic [1:0] STEP_UP    = 2'd2;
    localparam logic [1:0] STEP_DOWN  = 2'd3;

    t_state                        r_state,    n_state;
    t_addr                         r_clr_addr, n_clr_addr;
    t_res_kind                     r_kind,     n_kind;
    logic                          r_skip,     n_skip;
    logic [COL_BITS-1:0]           r_c,        n_c;
    logic [ROW_BITS-1:0]           r_r,        n_r;
    logic signed [COORD_BITS-1:0]  r_xs,       n_xs;
    logic signed [COORD_BITS-1:0]  r_ys,       n_ys;
    logic [COL_BITS-1:0]           r_x,        n_x;
    logic [ROW_BITS-1:0]           r_y,        n_y;
    logic [ROW_BITS-1:0]           r_y0,       n_y0;
    logic [SPAN_BITS-1:0]          r_nx,       n_nx;
    logic [SPAN_BITS-1:0]          r_ny,       n_ny;
    logic [SPAN_BITS-1:0]          r_xi,       n_xi;
    logic [SPAN_BITS-1:0]          r_yi,       n_yi;
    logic [1:0]                    r_step,     n_step;

    logic                          accept;
    logic                          in_grid;
    logic [RAD_BITS-1:0]           rad_eff;
    logic [RAD_BITS-1:0]           rad_sel;
    logic [DIM_BITS-1:0]           c_ext;
    logic [DIM_BITS-1:0]           r_ext;
    logic [DIM_BITS-1:0]           rad_ext;
    logic [DIM_BITS-1:0]           x_lo;
    logic [DIM_BITS-1:0]           x_hi;
    logic [DIM_BITS-1:0]           y_lo;
    logic [DIM_BITS-1:0]           y_hi;
    logic [COL_BITS-1:0]           x_inc;
    logic [ROW_BITS-1:0]           y_inc;
    logic                          x_last;
    logic                          y_last;
    logic [COL_BITS-1:0]           c_m1;
    logic [COL_BITS-1:0]           c_p1;
    logic [ROW_BITS-1:0]           r_m1;
    logic [ROW_BITS-1:0]           r_p1;
    logic                          c_p_ok;
    logic                          r_p_ok;
    logic [COL_BITS-1:0]           nb_x;
    logic [ROW_BITS-1:0]           nb_y;
    logic                          nb_ok;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // window bounds for a new word
    always_comb begin
        in_grid = (DIM_BITS'(i_in_word.col) < i_cfg.width)
               && (DIM_BITS'(i_in_word.row) < i_cfg.height);
        rad_eff = (i_in_word.radius > RAD_BITS'(MAX_RADIUS)) ? RAD_BITS'(MAX_RADIUS)
                                                             : i_in_word.radius;
        unique case (i_in_word.op)
            OP_READ:  rad_sel = '0;
            OP_EIGHT: rad_sel = RAD_BITS'(1);
            default:  rad_sel = rad_eff;
        endcase
        c_ext   = DIM_BITS'(i_in_word.col);
        r_ext   = DIM_BITS'(i_in_word.row);
        rad_ext = DIM_BITS'(rad_sel);
        x_lo    = (c_ext < rad_ext) ? '0 : (c_ext - rad_ext);
        y_lo    = (r_ext < rad_ext) ? '0 : (r_ext - rad_ext);
        x_hi    = ((c_ext + rad_ext) > (i_cfg.width - DIM_BITS'(1)))
                ? (i_cfg.width - DIM_BITS'(1)) : (c_ext + rad_ext);
        y_hi    = ((r_ext + rad_ext) > (i_cfg.height - DIM_BITS'(1)))
                ? (i_cfg.height - DIM_BITS'(1)) : (r_ext + rad_ext);
    end

    // scan stepping, wrapping at the grid edge
    always_comb begin
        x_inc  = ((DIM_BITS'(r_x) + DIM_BITS'(1)) == i_cfg.width) ? '0
               : (r_x + COL_BITS'(1));
        y_inc  = ((DIM_BITS'(r_y) + DIM_BITS'(1)) == i_cfg.height) ? '0
               : (r_y + ROW_BITS'(1));
        x_last = (r_xi == (r_nx - SPAN_BITS'(1)));
        y_last = (r_yi == (r_ny - SPAN_BITS'(1)));
    end

    // orthogonal neighbours
    always_comb begin
        c_m1   = (r_c == '0) ? COL_BITS'(i_cfg.width - DIM_BITS'(1)) : (r_c - COL_BITS'(1));
        r_m1   = (r_r == '0) ? ROW_BITS'(i_cfg.height - DIM_BITS'(1)) : (r_r - ROW_BITS'(1));
        c_p_ok = ((DIM_BITS'(r_c) + DIM_BITS'(1)) != i_cfg.width);
        r_p_ok = ((DIM_BITS'(r_r) + DIM_BITS'(1)) != i_cfg.height);
        c_p1   = c_p_ok ? (r_c + COL_BITS'(1)) : '0;
        r_p1   = r_p_ok ? (r_r + ROW_BITS'(1)) : '0;
        unique case (r_step)
            STEP_LEFT: begin
                nb_x  = c_m1;
                nb_y  = r_r;
                nb_ok = i_cfg.wrap || (r_c != '0);
            end
            STEP_RIGHT: begin
                nb_x  = c_p1;
                nb_y  = r_r;
                nb_ok = i_cfg.wrap || c_p_ok;
            end
            STEP_UP: begin
                nb_x  = r_c;
                nb_y  = r_m1;
                nb_ok = i_cfg.wrap || (r_r != '0);
            end
            STEP_DOWN: begin
                nb_x  = r_c;
                nb_y  = r_p1;
                nb_ok = i_cfg.wrap || r_p_ok;
            end
            default: begin
                nb_x  = r_c;
                nb_y  = r_r;
                nb_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_kind     = r_kind;
        n_skip     = r_skip;
        n_c        = r_c;
        n_r        = r_r;
        n_xs       = r_xs;
        n_ys       = r_ys;
        n_x        = r_x;
        n_y        = r_y;
        n_y0       = r_y0;
        n_nx       = r_nx;
        n_ny       = r_ny;
        n_xi       = r_xi;
        n_yi       = r_yi;
        n_step     = r_step;

        o_wr_en    = 1'b0;
        o_wr_addr  = {i_in_word.row, i_in_word.col};
        o_wr_data  = i_in_word.cell_state;
        o_rd_en    = 1'b0;
        o_rd_addr  = {r_y, r_x};

        o_cnt_ctrl         = '0;
        o_cnt_ctrl.clear   = accept;
        o_cnt_ctrl.st      = i_in_word.cell_state;
        o_cnt_ctrl.skip_en = r_skip;

        o_status.result_ready = (r_state == ST_DONE);
        o_status.kind         = r_kind;

        unique case (r_state)
            ST_CLEAR: begin
                o_wr_en    = 1'b1;
                o_wr_addr  = r_clr_addr;
                o_wr_data  = '0;
                n_clr_addr = r_clr_addr + ADDR_BITS'(1);
                if (r_clr_addr == ADDR_BITS'(CELLS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_c    = i_in_word.col;
                    n_r    = i_in_word.row;
                    n_skip = (i_in_word.op == OP_EIGHT);
                    if (i_cfg.wrap) begin
                        n_xs = $signed({1'b0, c_ext}) - $signed({1'b0, rad_ext});
                        n_ys = $signed({1'b0, r_ext}) - $signed({1'b0, rad_ext});
                        n_nx = {rad_sel, 1'b1};
                        n_ny = {rad_sel, 1'b1};
                    end else begin
                        n_xs = $signed({1'b0, x_lo});
                        n_ys = $signed({1'b0, y_lo});
                        n_nx = SPAN_BITS'(x_hi - x_lo + DIM_BITS'(1));
                        n_ny = SPAN_BITS'(y_hi - y_lo + DIM_BITS'(1));
                    end
                    n_step = STEP_LEFT;
                    if (!in_grid) begin
                        n_kind  = RES_ZERO;
                        n_state = ST_DONE;
                    end else begin
                        unique case (i_in_word.op)
                            OP_WRITE: begin
                                o_wr_en = 1'b1;
                                n_kind  = RES_ZERO;
                                n_state = ST_DONE;
                            end
                            OP_READ: begin
                                n_kind  = RES_READ;
                                n_state = ST_PREP;
                            end
                            OP_SQUARE, OP_EIGHT: begin
                                n_kind  = RES_COUNT;
                                n_state = ST_PREP;
                            end
                            OP_FOUR: begin
                                n_kind  = RES_COUNT;
                                n_state = ST_SCAN4;
                            end
                            default: begin
                                n_kind  = RES_ZERO;
                                n_state = ST_DONE;
                            end
                        endcase
                    end
                end
            end
            ST_PREP: begin
                // bring a negative start into range, one add of the grid size a cycle
                if (r_xs < 0) begin
                    n_xs = r_xs + $signed({1'b0, i_cfg.width});
                end
                if (r_ys < 0) begin
                    n_ys = r_ys + $signed({1'b0, i_cfg.height});
                end
                if ((r_xs >= 0) && (r_ys >= 0)) begin
                    n_x     = COL_BITS'(r_xs);
                    n_y     = ROW_BITS'(r_ys);
                    n_y0    = ROW_BITS'(r_ys);
                    n_xi    = '0;
                    n_yi    = '0;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_rd_en           = 1'b1;
                o_cnt_ctrl.sample = 1'b1;
                o_cnt_ctrl.centre = (r_x == r_c) && (r_y == r_r);
                if (y_last) begin
                    n_yi = '0;
                    n_y  = r_y0;
                    n_xi = r_xi + SPAN_BITS'(1);
                    n_x  = x_inc;
                    if (x_last) begin
                        n_state = ST_DRAIN;
                    end
                end else begin
                    n_yi = r_yi + SPAN_BITS'(1);
                    n_y  = y_inc;
                end
            end
            ST_SCAN4: begin
                o_rd_en           = nb_ok;
                o_rd_addr         = {nb_y, nb_x};
                o_cnt_ctrl.sample = nb_ok;
                n_step            = r_step + 2'd1;
                if (r_step == STEP_DOWN) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_kind     <= RES_ZERO;
            r_skip     <= 1'b0;
            r_nx       <= SPAN_BITS'(1);
            r_ny       <= SPAN_BITS'(1);
            r_xi       <= '0;
            r_yi       <= '0;
            r_step     <= STEP_LEFT;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_kind     <= n_kind;
            r_skip     <= n_skip;
            r_nx       <= n_nx;
            r_ny       <= n_ny;
            r_xi       <= n_xi;
            r_yi       <= n_yi;
            r_step     <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c  <= n_c;
        r_r  <= n_r;
        r_xs <= n_xs;
        r_ys <= n_ys;
        r_x  <= n_x;
        r_y  <= n_y;
        r_y0 <= n_y0;
    end

    `GNC_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, accept, !o_in_ready,
        "ready still high the cycle after a word was taken")
    `GNC_ASSERT_IMPL(a_scan_bounds, i_clk, i_rst_n, r_state == ST_SCAN,
        (r_xi < r_nx) && (r_yi < r_ny), "window scan index beyond window size")

endmodule

[hw/rtl/grid_neighbour_counter_core.sv]
`timescale 1ns / 1ps

// grid neighbour counter: a 64 x 64 grid of 4-bit cells held in one RAM.
// input channel (i_in_valid / o_in_ready / i_in_word) takes one word at a time:
// write cell, read cell, square-window count, four-neighbour or eight-neighbour
// count. each word gives exactly one result word on the output channel
// (o_out_valid / i_out_ready / o_out_word).
// the configuration port (i_cfg_we, i_cfg_index, i_cfg_data) sets grid width,
// grid height and wrap mode; write it only while no word is in flight.
// write, read of a cell outside the grid, or an unused op goes straight to the
// result without a RAM read. a count reads one cell a cycle through the single
// RAM read port: up to 225 window cells for radius 7, 9 for eight neighbours,
// 4 for four neighbours. a square or read word first adds the grid size to a
// wrapped start until it is in range (at most 7 adds), then scans and drains.
// a four-neighbour count skips that step. ready stays low until the result is
// moved into the output register, so one word is in flight at a time.
// after reset the RAM is cleared, one cell a cycle, all 4096 cells; input
// ready stays low meanwhile, configuration writes are taken.
// if the receiver stalls, the result holds in the output register, the next
// word is still taken, and its result waits until the register is free.

module grid_neighbour_counter_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  gnc_pkg::t_in_word                    i_in_word,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output gnc_pkg::t_out_word                   o_out_word,
    input  logic                                 i_cfg_we,
    input  logic [gnc_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [gnc_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);

    import gnc_pkg::*;

    logic [DIM_BITS-1:0] r_grid_width;
    logic [DIM_BITS-1:0] r_grid_height;
    logic                r_wrap_mode;

    logic                r_out_valid;
    t_out_word           r_out_word;
    t_out_word           n_out_word;

    t_grid_cfg           grid_cfg;
    t_seq_status         seq_status;
    t_cnt_ctrl           cnt_ctrl;
    logic                out_free;
    logic                out_load;
    logic                wr_en;
    t_addr               wr_addr;
    t_cell               wr_data;
    logic                rd_en;
    t_addr               rd_addr;
    t_cell               rd_data;
    t_count              count;
    t_cell               value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= DIM_BITS'(MAX_COLS);
            r_grid_height <= DIM_BITS'(MAX_ROWS);
            r_wrap_mode   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GRID_WIDTH:  r_grid_width  <= DIM_BITS'(i_cfg_data);
                CFG_GRID_HEIGHT: r_grid_height <= DIM_BITS'(i_cfg_data);
                CFG_WRAP_MODE:   r_wrap_mode   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // zero acts as one, oversize clamps to the grid
    always_comb begin
        if (r_grid_width == '0) begin
            grid_cfg.width = DIM_BITS'(1);
        end else if (r_grid_width > DIM_BITS'(MAX_COLS)) begin
            grid_cfg.width = DIM_BITS'(MAX_COLS);
        end else begin
            grid_cfg.width = r_grid_width;
        end
        if (r_grid_height == '0) begin
            grid_cfg.height = DIM_BITS'(1);
        end else if (r_grid_height > DIM_BITS'(MAX_ROWS)) begin
            grid_cfg.height = DIM_BITS'(MAX_ROWS);
        end else begin
            grid_cfg.height = r_grid_height;
        end
        grid_cfg.wrap = r_wrap_mode;
    end

    gnc_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .i_cfg      (grid_cfg),
        .i_out_free (out_free),
        .o_status   (seq_status),
        .o_cnt_ctrl (cnt_ctrl),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr)
    );

    gnc_ram #(
        .WIDTH (STATE_BITS),
        .DEPTH (CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    gnc_count u_count (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (cnt_ctrl),
        .i_rd_data (rd_data),
        .o_count   (count),
        .o_value   (value)
    );

    assign out_free = !r_out_valid || i_out_ready;
    assign out_load = seq_status.result_ready && out_free;

    always_comb begin
        n_out_word = '0;
        unique case (seq_status.kind)
            RES_READ:  n_out_word.cell_value  = value;
            RES_COUNT: n_out_word.match_count = count;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
